/* hw/rtl/gte_pkg.sv */
package gte_pkg;

	// Sizes
	localparam int MAX_LENGTH_DEFAULT = 1024;
	localparam int QUEUE_DEPTH        = 2;
	localparam int LEAD_LEN           = 6;
	localparam int TIME_FIRST         = 7;
	localparam int TIME_LAST          = 12;
	localparam int TIME_DIGITS        = 6;

	localparam logic [4:0] HOUR_OFFSET_RESET = 5'd8;

	// Characters of the sentence grammar
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] CHAR_F      = 8'h46;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_P      = 8'h50;
	localparam logic [7:0] CHAR_R      = 8'h52;
	localparam logic [7:0] CHAR_M      = 8'h4D;
	localparam logic [7:0] CHAR_C      = 8'h43;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_req_t;

	typedef struct packed {
		logic [4:0] out_hour;
		logic [6:0] out_minute;
		logic [6:0] out_second;
		logic       updated;
	} out_req_t;

	// One finished sentence as handed from the parser to the time stage
	typedef struct packed {
		logic                         valid;
		digit_t [TIME_DIGITS-1:0]     digits;
	} sentence_t;

endpackage

/* hw/rtl/gte_front.sv */
module gte_front import gte_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_req_t   in_req,
	output logic      push,
	output sentence_t push_data,
	input  logic      q_full
);

	localparam int PosW = $clog2(MAX_LENGTH + 1);

	// Expected text of the sentence head
	function automatic logic [7:0] lead_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = CHAR_DOLLAR;
			3'd1:    ch = CHAR_G;
			3'd2:    ch = CHAR_P;
			3'd3:    ch = CHAR_R;
			3'd4:    ch = CHAR_M;
			3'd5:    ch = CHAR_C;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Decode one upper-case hex digit: {bad, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] ch);
		logic [4:0] r;
		if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			r = {1'b0, ch[3:0]};
		end else if (ch >= CHAR_A && ch <= CHAR_F) begin
			r = {1'b0, 4'(ch[3:0] + 4'd9)};
		end else begin
			r = {1'b1, 4'd0};
		end
		return r;
	endfunction

	logic [PosW-1:0] pos_q, pos_d;
	logic [7:0]      xor_q, xor_d;
	logic [7:0]      rsum_q, rsum_d;
	logic [1:0]      hex_cnt_q, hex_cnt_d;
	logic            prefix_ok_q, prefix_ok_d;
	logic            star_q, star_d;
	logic            comma_q, comma_d;
	logic            status_ok_q, status_ok_d;
	logic            pending_q, pending_d;
	logic            reject_q, reject_d;
	digit_t [TIME_DIGITS-1:0] digits_q, digits_d;

	logic       accept;
	logic [7:0] ch;
	logic [2:0] tidx;
	logic [4:0] hexv;
	logic       sent_ok;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;
	assign ch       = in_req.data_byte;
	assign tidx     = 3'(pos_q - PosW'(TIME_FIRST));
	assign hexv     = hex_decode(ch);

	// Classify the incoming byte against the parse state
	always_comb begin
		pos_d       = pos_q;
		xor_d       = xor_q;
		rsum_d      = rsum_q;
		hex_cnt_d   = hex_cnt_q;
		prefix_ok_d = prefix_ok_q;
		star_d      = star_q;
		comma_d     = comma_q;
		status_ok_d = status_ok_q;
		pending_d   = pending_q;
		reject_d    = reject_q;
		digits_d    = digits_q;
		if (pos_q >= PosW'(MAX_LENGTH)) begin
			reject_d = 1'b1;
		end else begin
			if (pos_q < PosW'(LEAD_LEN) && ch != lead_char(pos_q[2:0])) begin
				prefix_ok_d = 1'b0;
			end
			if (pending_q) begin
				pending_d   = 1'b0;
				status_ok_d = (ch == CHAR_A);
			end
			if (pos_q >= PosW'(TIME_FIRST) && pos_q <= PosW'(TIME_LAST)) begin
				if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
					digits_d[tidx] = ch[3:0];
				end else begin
					reject_d = 1'b1;
				end
			end
			if (star_q) begin
				if (hex_cnt_q != 2'd2) begin
					if (hexv[4]) begin
						reject_d = 1'b1;
					end else begin
						rsum_d = {rsum_q[3:0], hexv[3:0]};
					end
					hex_cnt_d = hex_cnt_q + 2'd1;
				end
			end else if (pos_q != '0) begin
				if (ch == CHAR_STAR) begin
					star_d = 1'b1;
				end else begin
					xor_d = xor_q ^ ch;
					if (ch == CHAR_COMMA && pos_q >= PosW'(TIME_FIRST) && !comma_q) begin
						comma_d   = 1'b1;
						pending_d = 1'b1;
					end
				end
			end
			pos_d = pos_q + PosW'(1);
		end
	end

	// Judge the sentence on its last byte
	assign sent_ok = prefix_ok_d && !reject_d && star_d && (hex_cnt_d == 2'd2) &&
		comma_d && status_ok_d && (rsum_d == xor_d);

	assign push             = accept && in_req.last_byte;
	assign push_data.valid  = sent_ok;
	assign push_data.digits = digits_d;

	// Advance the parse state, restart after each sentence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			xor_q       <= '0;
			rsum_q      <= '0;
			hex_cnt_q   <= '0;
			prefix_ok_q <= 1'b1;
			star_q      <= 1'b0;
			comma_q     <= 1'b0;
			status_ok_q <= 1'b0;
			pending_q   <= 1'b0;
			reject_q    <= 1'b0;
			digits_q    <= '0;
		end else if (accept) begin
			if (in_req.last_byte) begin
				pos_q       <= '0;
				xor_q       <= '0;
				rsum_q      <= '0;
				hex_cnt_q   <= '0;
				prefix_ok_q <= 1'b1;
				star_q      <= 1'b0;
				comma_q     <= 1'b0;
				status_ok_q <= 1'b0;
				pending_q   <= 1'b0;
				reject_q    <= 1'b0;
				digits_q    <= '0;
			end else begin
				pos_q       <= pos_d;
				xor_q       <= xor_d;
				rsum_q      <= rsum_d;
				hex_cnt_q   <= hex_cnt_d;
				prefix_ok_q <= prefix_ok_d;
				star_q      <= star_d;
				comma_q     <= comma_d;
				status_ok_q <= status_ok_d;
				pending_q   <= pending_d;
				reject_q    <= reject_d;
				digits_q    <= digits_d;
			end
		end
	end

endmodule

/* hw/rtl/gte_fifo.sv */
module gte_fifo import gte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sentence_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      valid,
	output sentence_t pop_data
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	sentence_t [QUEUE_DEPTH-1:0] slot_q;
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == CntW'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Store a finished sentence
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

/* hw/rtl/gte_back.sv */
module gte_back import gte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic      q_valid,
	input  sentence_t q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_req_t  out_req
);

	// Reduce a value below 128+24 modulo 24
	function automatic logic [4:0] mod24(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (r >= 8'd96) r = r - 8'd96;
		if (r >= 8'd48) r = r - 8'd48;
		if (r >= 8'd24) r = r - 8'd24;
		return 5'(r);
	endfunction

	logic [4:0] hour_offset_q;
	logic       out_valid_q;
	logic       updated_q;
	logic [4:0] held_hour_q;
	logic [6:0] held_minute_q;
	logic [6:0] held_second_q;

	logic [6:0] hour_utc, minute_val, second_val;
	logic [7:0] hour_sum;

	// Combine digit pairs
	assign hour_utc   = 7'(q_data.digits[0]) * 7'd10 + 7'(q_data.digits[1]);
	assign minute_val = 7'(q_data.digits[2]) * 7'd10 + 7'(q_data.digits[3]);
	assign second_val = 7'(q_data.digits[4]) * 7'd10 + 7'(q_data.digits[5]);
	assign hour_sum   = {1'b0, hour_utc} + {3'b0, hour_offset_q};

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_req   = '{out_hour: held_hour_q, out_minute: held_minute_q,
		out_second: held_second_q, updated: updated_q};

	// Hold the configured hour offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_offset_q <= HOUR_OFFSET_RESET;
		end else if (cfg_we) begin
			hour_offset_q <= cfg_wdata;
		end
	end

	// Update held time and present one result per sentence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			updated_q     <= 1'b0;
			held_hour_q   <= '0;
			held_minute_q <= '0;
			held_second_q <= '0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
			updated_q   <= q_data.valid;
			if (q_data.valid) begin
				held_hour_q   <= mod24(hour_sum);
				held_minute_q <= minute_val;
				held_second_q <= second_val;
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/gprmc_time_extractor.sv */
// GPRMC time extractor: takes one NMEA byte per cycle (last_byte marks the end of a
// sentence) and, for every sentence, returns the held local time plus an updated flag
// that is set when the sentence began with $GPRMC, carried a matching two-digit hex
// checksum, status 'A' and six decimal time digits. The hour is shifted by hour_offset
// (reset 8) modulo 24; write the offset only while no sentence is in flight. Bytes are
// taken every cycle unless the sentence queue is full. A two-entry sentence queue sits
// between the byte parser and the time stage, so input stalls only once two finished
// sentences wait behind a stalled output.
module gprmc_time_extractor import gte_pkg::*; #(
	parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_req_t    in_req,
	output logic       out_valid,
	input  logic       out_stall,
	output out_req_t   out_req,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);

	logic      q_push, q_full, q_valid, q_pop;
	sentence_t q_wdata, q_rdata;

	gte_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.push     (q_push),
		.push_data(q_wdata),
		.q_full   (q_full)
	);

	gte_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_data (q_rdata)
	);

	gte_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_valid  (q_valid),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_req  (out_req)
	);

`ifndef ASSERT_OFF
	// Held hour is always a valid clock hour
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_req.out_hour < 5'd24))
		else $error("held hour out of range");

	// A new result shows only after a sentence sat in the queue
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_valid))
		else $error("result without queued sentence");

	// A result leaves only when the consumer takes it
	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped while stalled");
`endif

endmodule
